// File: design/i2c_rts_pkg.sv
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - shared definitions
// Item types, phase encoding, bus command and status codes.
// ----------------------------------------------------------------------------
package i2c_rts_pkg;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START1 = 4'd1,
		PH_ADDRW  = 4'd2,
		PH_REG    = 4'd3,
		PH_DATA   = 4'd4,
		PH_START2 = 4'd5,
		PH_ADDRR  = 4'd6,
		PH_RECV   = 4'd7
	} phase_t;

	// Operation codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_STATUS  = 1'b1;

	// Transfer kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ1 = 2'd1;
	localparam logic [1:0] KIND_READN = 2'd2;

	// Bus commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_SEND  = 3'd2;
	localparam logic [2:0] CMD_RXACK = 3'd3;
	localparam logic [2:0] CMD_RXNAK = 3'd4;

	// Bus engine status codes (after masking)
	localparam logic [7:0] STATUS_MASK   = 8'hF8;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RSTART     = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_RX_ACK     = 8'h50;
	localparam logic [7:0] ST_RX_NACK    = 8'h58;

	// Register auto-increment flag for multi-byte reads
	localparam logic [7:0] REG_AUTO_INC  = 8'h80;

	typedef struct packed {
		logic       operation;
		logic [1:0] transfer_kind;
		logic [6:0] target_address;
		logic [7:0] register_address;
		logic [7:0] write_value;
		logic [7:0] byte_count;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0] bus_command;
		logic [7:0] command_byte;
		logic [7:0] read_byte;
		logic       read_valid;
		logic [7:0] read_index;
		logic       done_res;
		logic       success;
	} out_item_t;

endpackage

// File: design/i2c_register_transaction_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - top level
// Drives a byte-level I2C bus engine through register write, single read and
// auto-incrementing multi-byte read transfers, one answer per item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | in        | in_valid / in_ready   | in_item  (request or status)
//  out     | out       | out_valid / out_ready | out_item (command / result)
//
// One item per cycle sustained while out_ready holds; each item gives exactly one
// result, which passes the input register, then the result register.
// The sequencer state is updated as the input register hands its item to the
// result register, so a following item already sees the new phase.
// A stalled result register holds its item; the input register still takes
// one more item, then in_ready drops until the result is taken.
// arst_n clears the phase, the held request fields and both valid flags.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_top
	import i2c_rts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// Input register stage
	logic      s1_valid_s1;
	in_item_t  item_s1;

	// Sequencer state
	phase_t     phase_q;
	logic [1:0] kind_q;
	logic [6:0] addr_q;
	logic [7:0] reg_q;
	logic [7:0] value_q;
	logic [7:0] count_q;
	logic [7:0] rcvd_q;

	// Result register
	logic      res_valid_q;
	out_item_t res_q;

	// Combinational next state
	phase_t     phase_d;
	logic [7:0] rcvd_d;
	logic [7:0] rcvd_inc;
	logic [7:0] status;
	logic       load_req;
	out_item_t  res_d;
	logic       advance;

	// Stage 1 moves on whenever the result register is free or being drained
	assign advance  = s1_valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Next-phase and answer logic
	assign status   = item_s1.bus_status & STATUS_MASK;
	assign rcvd_inc = rcvd_q + 8'd1;

	always_comb begin
		res_d    = '0;
		phase_d  = phase_q;
		rcvd_d   = rcvd_q;
		load_req = 1'b0;
		if (item_s1.operation == OP_REQUEST) begin
			// Requests are only taken while idle and with a known kind
			if (phase_q == PH_IDLE && item_s1.transfer_kind <= KIND_READN) begin
				load_req          = 1'b1;
				rcvd_d            = '0;
				phase_d           = PH_START1;
				res_d.bus_command = CMD_START;
			end
		end else begin
			unique case (phase_q)
				PH_START1, PH_START2: begin
					if (status == ST_START || status == ST_RSTART) begin
						res_d.bus_command  = CMD_SEND;
						res_d.command_byte = {addr_q, phase_q == PH_START2};
						phase_d = (phase_q == PH_START1) ? PH_ADDRW : PH_ADDRR;
					end else begin
						res_d.done_res = 1'b1;
						phase_d        = PH_IDLE;
					end
				end
				PH_ADDRW: begin
					if (status == ST_SLAW_ACK) begin
						res_d.bus_command  = CMD_SEND;
						res_d.command_byte = (kind_q == KIND_READN) ? (reg_q | REG_AUTO_INC)
						                                            : reg_q;
						phase_d = PH_REG;
					end else begin
						res_d.done_res = 1'b1;
						phase_d        = PH_IDLE;
					end
				end
				PH_REG: begin
					if (status != ST_DATA_ACK) begin
						res_d.done_res = 1'b1;
						phase_d        = PH_IDLE;
					end else if (kind_q == KIND_WRITE) begin
						res_d.bus_command  = CMD_SEND;
						res_d.command_byte = value_q;
						phase_d            = PH_DATA;
					end else begin
						res_d.bus_command = CMD_START;
						phase_d           = PH_START2;
					end
				end
				PH_DATA: begin
					res_d.done_res = 1'b1;
					res_d.success  = (status == ST_DATA_ACK);
					phase_d        = PH_IDLE;
				end
				PH_ADDRR: begin
					if (status != ST_SLAR_ACK) begin
						res_d.done_res = 1'b1;
						phase_d        = PH_IDLE;
					end else if (kind_q == KIND_READN) begin
						rcvd_d = '0;
						if (count_q == 8'd0) begin
							// nothing to read: done once SLA+R is acknowledged
							res_d.done_res = 1'b1;
							res_d.success  = 1'b1;
							phase_d        = PH_IDLE;
						end else begin
							res_d.bus_command = CMD_RXACK;
							phase_d           = PH_RECV;
						end
					end else begin
						res_d.bus_command = CMD_RXNAK;
						phase_d           = PH_RECV;
					end
				end
				PH_RECV: begin
					if (kind_q == KIND_READN) begin
						if (status == ST_RX_ACK) begin
							res_d.read_byte  = item_s1.bus_data;
							res_d.read_valid = 1'b1;
							res_d.read_index = rcvd_q;
							rcvd_d           = rcvd_inc;
							if (rcvd_inc == count_q) begin
								// last byte and completion in one result
								res_d.done_res = 1'b1;
								res_d.success  = 1'b1;
								phase_d        = PH_IDLE;
							end else begin
								res_d.bus_command = CMD_RXACK;
							end
						end else begin
							res_d.done_res = 1'b1;
							phase_d        = PH_IDLE;
						end
					end else begin
						if (status == ST_RX_NACK) begin
							res_d.read_byte  = item_s1.bus_data;
							res_d.read_valid = 1'b1;
							res_d.success    = 1'b1;
						end
						res_d.done_res = 1'b1;
						phase_d        = PH_IDLE;
					end
				end
				default: begin
					// status while idle: ignored, all-zero answer
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= '0;
			addr_q  <= '0;
			reg_q   <= '0;
			value_q <= '0;
			count_q <= '0;
			rcvd_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			rcvd_q  <= rcvd_d;
			if (load_req) begin
				kind_q  <= item_s1.transfer_kind;
				addr_q  <= item_s1.target_address;
				reg_q   <= item_s1.register_address;
				value_q <= item_s1.write_value;
				count_q <= item_s1.byte_count;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	// Checks
	a_success_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_item.success || out_item.done_res))
		else $error("success without done_res");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.done_res) |=> (phase_q == PH_IDLE))
		else $error("phase not idle after finish");

	a_done_no_command: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.done_res) |-> (out_item.bus_command == CMD_NONE))
		else $error("command issued with done_res");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !in_ready) |=> s1_valid_s1)
		else $error("stalled input item lost");

	a_read_in_recv: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.read_valid) |-> (phase_q == PH_RECV))
		else $error("read byte outside receive phase");

endmodule
